@@ hw/rtl/lcs_pkg.sv @@
// Shared constants, types and control structures for the lottery scheduler.
`timescale 1ns / 1ps

package lcs_pkg;

    // Sizing of the ready list and the processor set.
    localparam int QUEUE_DEPTH = 16;
    localparam int NUM_CPUS    = 4;

    // Field widths.
    localparam int PID_W  = 16;
    localparam int RND_W  = 32;
    localparam int QL_W   = 8;
    localparam int CPU_W  = 2;
    localparam int KIND_W = 2;

    // Derived widths.
    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int CIDX_W  = $clog2(NUM_CPUS);
    localparam int STEP_W  = $clog2(RND_W);

    // Ticket arithmetic.
    localparam int QUANTUM_RESET    = 10;
    localparam int TICKETS_PER_TICK = 1000;
    localparam int PER_W            = $clog2(((1 << QL_W) - 1) * TICKETS_PER_TICK + 1);
    localparam int TOT_W            = PER_W + CNT_W;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_QUANTUM = 1'b0;

    // Event kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD  = 2'd0,
        KIND_TICK  = 2'd1,
        KIND_BLOCK = 2'd2,
        KIND_EXIT  = 2'd3
    } lcs_kind_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DRAW,
        ST_MOD_INIT,
        ST_MOD,
        ST_IDX_INIT,
        ST_IDX,
        ST_WIN_RD,
        ST_WIN_TAKE,
        ST_SH_RD,
        ST_SH_WR,
        ST_RESULT
    } lcs_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;
        logic enq_new;
        logic enq_run;
        logic dec_q;
        logic draw_init;
        logic go_idle;
        logic mod_init;
        logic mod_step;
        logic idx_init;
        logic idx_step;
        logic win_rd;
        logic win_take;
        logic sh_wr;
        logic cnt_dec;
    } lcs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        lcs_kind_t kind;
        logic      cpu_ok;
        logic      cur_idle;
        logic      q_expire;
        logic      cnt_zero;
        logic      step_last;
        logic      sh_more;
    } lcs_stat_t;

endpackage

@@ hw/rtl/lcs_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module lcs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/lcs_ctrl.sv @@
// Controller state machine that sequences each scheduler event.
`timescale 1ns / 1ps

module lcs_ctrl import lcs_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  lcs_stat_t stat,
    output lcs_cmd_t  cmd,
    output logic      busy,
    output logic      done
);

    lcs_state_t state_reg;
    lcs_state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        done       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (stat.kind == KIND_LOAD)
                begin
                    cmd.enq_new = 1'b1;
                    state_next  = ST_IDLE;
                end
                else if (!stat.cpu_ok)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.kind == KIND_TICK)
                begin
                    if (stat.cur_idle)
                    begin
                        state_next = stat.cnt_zero ? ST_RESULT : ST_DRAW;
                    end
                    else if (stat.q_expire)
                    begin
                        // Preempted process goes back on the list before the draw.
                        cmd.enq_run = 1'b1;
                        state_next  = ST_DRAW;
                    end
                    else
                    begin
                        cmd.dec_q  = 1'b1;
                        state_next = ST_RESULT;
                    end
                end
                else
                begin
                    state_next = ST_DRAW;
                end
            end
            ST_DRAW:
            begin
                cmd.draw_init = 1'b1;
                if (stat.cnt_zero)
                begin
                    cmd.go_idle = 1'b1;
                    state_next  = ST_RESULT;
                end
                else
                begin
                    state_next = ST_MOD_INIT;
                end
            end
            ST_MOD_INIT:
            begin
                cmd.mod_init = 1'b1;
                state_next   = ST_MOD;
            end
            ST_MOD:
            begin
                cmd.mod_step = 1'b1;
                if (stat.step_last)
                begin
                    state_next = ST_IDX_INIT;
                end
            end
            ST_IDX_INIT:
            begin
                cmd.idx_init = 1'b1;
                state_next   = ST_IDX;
            end
            ST_IDX:
            begin
                cmd.idx_step = 1'b1;
                if (stat.step_last)
                begin
                    state_next = ST_WIN_RD;
                end
            end
            ST_WIN_RD:
            begin
                cmd.win_rd = 1'b1;
                state_next = ST_WIN_TAKE;
            end
            ST_WIN_TAKE:
            begin
                cmd.win_take = 1'b1;
                state_next   = ST_SH_RD;
            end
            ST_SH_RD:
            begin
                // The read of the next entry is issued here whenever one remains.
                if (stat.sh_more)
                begin
                    state_next = ST_SH_WR;
                end
                else
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = ST_RESULT;
                end
            end
            ST_SH_WR:
            begin
                cmd.sh_wr  = 1'b1;
                state_next = ST_SH_RD;
            end
            ST_RESULT:
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/lcs_dp.sv @@
// Datapath: ready list, per-CPU state, ticket arithmetic and the serial divider.
`timescale 1ns / 1ps

module lcs_dp import lcs_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  lcs_cmd_t            cmd,
    output lcs_stat_t           stat,
    input  logic [KIND_W-1:0]   kind,
    input  logic [CPU_W-1:0]    cpu,
    input  logic [PID_W-1:0]    pid,
    input  logic [RND_W-1:0]    random_value,
    input  logic [QL_W-1:0]     quantum,
    output logic [PID_W-1:0]    next_pid,
    output logic                is_idle,
    output logic [CPU_W-1:0]    cpu_out
);

    // Event registers.
    lcs_kind_t          kind_reg, kind_next;
    logic [CPU_W-1:0]   cpu_reg, cpu_next;
    logic [PID_W-1:0]   pid_reg, pid_next;

    // Ready list fill count and per-CPU state.
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [PID_W-1:0]   run_pid_reg [NUM_CPUS];
    logic [PID_W-1:0]   run_pid_next [NUM_CPUS];
    logic               run_idle_reg [NUM_CPUS];
    logic               run_idle_next [NUM_CPUS];
    logic [QL_W-1:0]    qleft_reg [NUM_CPUS];
    logic [QL_W-1:0]    qleft_next [NUM_CPUS];

    // Draw arithmetic.
    logic [PER_W-1:0]   per_reg, per_next;
    logic [TOT_W-1:0]   total_reg, total_next;
    logic [TOT_W-1:0]   rem_reg, rem_next;
    logic [TOT_W-1:0]   dsr_reg, dsr_next;
    logic [RND_W-1:0]   dvd_reg, dvd_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   ptr_reg, ptr_next;

    // Helpers.
    logic [CIDX_W-1:0]  sel;
    logic [QL_W-1:0]    q_eff;
    logic               enq;
    logic               full;
    logic [TOT_W:0]     shifted;
    logic               mod_fits;
    logic               idx_fits;
    logic [IDX_W-1:0]   idx_fix;
    logic [IDX_W-1:0]   ptr_inc;

    // Ready list memory ports.
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [PID_W-1:0]   ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [PID_W-1:0]   ram_rdata;

    assign sel      = cpu_reg[CIDX_W-1:0];
    assign q_eff    = (quantum == '0) ? QL_W'(1) : quantum;
    assign enq      = cmd.enq_new | cmd.enq_run;
    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign shifted  = {rem_reg, dvd_reg[RND_W-1]};
    assign mod_fits = (shifted >= {1'b0, total_reg});
    assign idx_fits = (rem_reg >= dsr_reg);
    assign ptr_inc  = ptr_reg + IDX_W'(1);

    // Guard the winner index against the list length.
    assign idx_fix = (CNT_W'(idx_reg) >= count_reg) ? IDX_W'(count_reg - CNT_W'(1)) : idx_reg;

    // Memory port selection: appends, compaction writes, winner and shift reads.
    assign ram_we    = (enq && !full) || cmd.sh_wr;
    assign ram_waddr = enq ? count_reg[IDX_W-1:0] : ptr_reg;
    assign ram_wdata = cmd.enq_new ? pid_reg : (cmd.enq_run ? run_pid_reg[sel] : ram_rdata);
    assign ram_raddr = cmd.win_rd ? idx_fix : ptr_inc;

    lcs_ram #(
        .WIDTH(PID_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_ready_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Next-state logic for every datapath register.
    always_comb
    begin
        kind_next     = kind_reg;
        cpu_next      = cpu_reg;
        pid_next      = pid_reg;
        count_next    = count_reg;
        run_pid_next  = run_pid_reg;
        run_idle_next = run_idle_reg;
        qleft_next    = qleft_reg;
        per_next      = per_reg;
        total_next    = total_reg;
        rem_next      = rem_reg;
        dsr_next      = dsr_reg;
        dvd_next      = dvd_reg;
        step_next     = step_reg;
        idx_next      = idx_reg;
        ptr_next      = ptr_reg;

        if (cmd.latch)
        begin
            kind_next = lcs_kind_t'(kind);
            cpu_next  = cpu;
            pid_next  = pid;
            dvd_next  = random_value;
        end

        // Appends to a full list are dropped.
        if (enq && !full)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.cnt_dec)
        begin
            count_next = count_reg - CNT_W'(1);
        end

        if (cmd.dec_q)
        begin
            qleft_next[sel] = qleft_reg[sel] - QL_W'(1);
        end

        // Fresh quantum and tickets per entry.
        if (cmd.draw_init)
        begin
            qleft_next[sel] = q_eff;
            per_next        = PER_W'(q_eff * TICKETS_PER_TICK);
        end
        if (cmd.go_idle)
        begin
            run_idle_next[sel] = 1'b1;
            run_pid_next[sel]  = '0;
        end

        // Ticket total, then the remainder one dividend bit per cycle.
        if (cmd.mod_init)
        begin
            total_next = TOT_W'(TOT_W'(count_reg) * TOT_W'(per_reg));
            rem_next   = '0;
            step_next  = STEP_W'(RND_W - 1);
        end
        if (cmd.mod_step)
        begin
            rem_next  = mod_fits ? TOT_W'(shifted - {1'b0, total_reg}) : shifted[TOT_W-1:0];
            dvd_next  = dvd_reg << 1;
            step_next = step_reg - STEP_W'(1);
        end

        // Winner index: the ticket divided by the tickets per entry, one bit per cycle.
        if (cmd.idx_init)
        begin
            dsr_next  = TOT_W'(per_reg) << (IDX_W - 1);
            idx_next  = '0;
            step_next = STEP_W'(IDX_W - 1);
        end
        if (cmd.idx_step)
        begin
            if (idx_fits)
            begin
                rem_next = rem_reg - dsr_reg;
            end
            dsr_next  = dsr_reg >> 1;
            idx_next  = IDX_W'({idx_reg, idx_fits});
            step_next = step_reg - STEP_W'(1);
        end

        if (cmd.win_rd)
        begin
            ptr_next = idx_fix;
        end
        if (cmd.win_take)
        begin
            run_pid_next[sel]  = ram_rdata;
            run_idle_next[sel] = 1'b0;
        end
        if (cmd.sh_wr)
        begin
            ptr_next = ptr_inc;
        end
    end

    // Control state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            for (int i = 0; i < NUM_CPUS; i++)
            begin
                run_pid_reg[i]  <= '0;
                run_idle_reg[i] <= 1'b1;
                qleft_reg[i]    <= QL_W'(QUANTUM_RESET);
            end
        end
        else
        begin
            count_reg    <= count_next;
            run_pid_reg  <= run_pid_next;
            run_idle_reg <= run_idle_next;
            qleft_reg    <= qleft_next;
        end
    end

    // Payload and arithmetic registers.
    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        cpu_reg   <= cpu_next;
        pid_reg   <= pid_next;
        per_reg   <= per_next;
        total_reg <= total_next;
        rem_reg   <= rem_next;
        dsr_reg   <= dsr_next;
        dvd_reg   <= dvd_next;
        step_reg  <= step_next;
        idx_reg   <= idx_next;
        ptr_reg   <= ptr_next;
    end

    // Status toward the controller.
    always_comb
    begin
        stat.kind      = kind_reg;
        stat.cpu_ok    = (32'(cpu_reg) < NUM_CPUS);
        stat.cur_idle  = run_idle_reg[sel];
        stat.q_expire  = (qleft_reg[sel] <= QL_W'(1));
        stat.cnt_zero  = (count_reg == '0);
        stat.step_last = (step_reg == '0);
        stat.sh_more   = ((CNT_W'(ptr_reg) + CNT_W'(1)) < count_reg);
    end

    // Result fields for the CPU of the current event.
    assign next_pid = run_idle_reg[sel] ? '0 : run_pid_reg[sel];
    assign is_idle  = run_idle_reg[sel];
    assign cpu_out  = cpu_reg;

endmodule

@@ hw/rtl/lottery_cpu_scheduler_unit.sv @@
// Top level of the lottery CPU scheduler: configuration port, controller and datapath.
// A load only appends; a draw runs the 32-step remainder loop and the index division,
// then compacts the entries after the winner through the list RAM.
// One event at a time, busy while it runs; a load ends without a result strobe.
// Reset clears the list, makes every CPU idle and sets the quantum to 10.
`timescale 1ns / 1ps

module lottery_cpu_scheduler_unit import lcs_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [KIND_W-1:0]   kind,
    input  logic [CPU_W-1:0]    cpu,
    input  logic [PID_W-1:0]    pid,
    input  logic [RND_W-1:0]    random_value,
    output logic                done,
    output logic [PID_W-1:0]    next_pid,
    output logic                is_idle,
    output logic [CPU_W-1:0]    cpu_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    logic [QL_W-1:0] quantum_length_reg;
    logic [QL_W-1:0] quantum_length_next;
    logic            reg_hit;
    lcs_cmd_t        cmd;
    lcs_stat_t       stat;

    // Register decode and write transfer.
    assign reg_hit = (paddr[PADDR_W-1:2] == REG_QUANTUM);
    assign pready  = 1'b1;
    assign prdata  = reg_hit ? PDATA_W'(quantum_length_reg) : '0;

    always_comb
    begin
        quantum_length_next = quantum_length_reg;
        if (psel && penable && pwrite && reg_hit)
        begin
            quantum_length_next = pwdata[QL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_length_reg <= QL_W'(QUANTUM_RESET);
        end
        else
        begin
            quantum_length_reg <= quantum_length_next;
        end
    end

    lcs_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .stat (stat),
        .cmd  (cmd),
        .busy (busy),
        .done (done)
    );

    lcs_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .kind        (kind),
        .cpu         (cpu),
        .pid         (pid),
        .random_value(random_value),
        .quantum     (quantum_length_reg),
        .next_pid    (next_pid),
        .is_idle     (is_idle),
        .cpu_out     (cpu_out)
    );

endmodule

@@ hw/rtl/lcs_checker.sv @@
// Port-level checker for the lottery scheduler, bound to the top level.
`timescale 1ns / 1ps

module lcs_checker import lcs_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input logic [PID_W-1:0] next_pid,
    input logic             is_idle
);

    // An accepted transfer makes the block busy.
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted event did not raise busy");

    // A result only appears while an event is in progress.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe outside an event");

    // At most one result per event, then the block is free again.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy))
        else $error("result strobe not followed by idle");

    // An idle CPU reports the null process id.
    a_idle_pid: assert property (@(posedge clk) disable iff (!rst_n)
        (done && is_idle) |-> (next_pid == '0))
        else $error("idle result with nonzero pid");

endmodule

bind lottery_cpu_scheduler_unit lcs_checker u_lcs_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .done    (done),
    .next_pid(next_pid),
    .is_idle (is_idle)
);
